// ----- rtl/nus_pkg.sv -----
// nal unit splitter package: result item type, queue push bundle, constants
// used by the front, queue and back modules; no dependencies

package nus_pkg;

	localparam int unsigned PosW      = 16;
	localparam int unsigned LenW      = 16;
	localparam int unsigned QDepth    = 4;
	localparam int unsigned QAddrW    = 2;
	localparam int unsigned QCountW   = 3;
	localparam logic [15:0] MaxLenRst = 16'd1200;
	localparam logic [15:0] StartSkip = 16'd3;

	typedef struct packed {
		logic [PosW-1:0] unit_offset;
		logic [LenW-1:0] unit_length;
		logic            end_of_frame;
		logic            oversize;
		logic            final_of_item;
	} unit_res_t;

	// up to two result items written into the queue in one cycle
	typedef struct packed {
		logic [1:0] count;
		unit_res_t  first;
		unit_res_t  second;
	} push_t;

endpackage

// ----- rtl/nus_if.sv -----
// valid/ready channel interfaces for the nal unit splitter
// byte channel in, unit result channel out; no dependencies

interface nus_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nus_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] unit_offset;
	logic [15:0] unit_length;
	logic        end_of_frame;
	logic        oversize;
	logic        final_of_item;

	modport source (output valid, output unit_offset, output unit_length,
		output end_of_frame, output oversize, output final_of_item, input ready);
	modport sink (input valid, input unit_offset, input unit_length,
		input end_of_frame, input oversize, input final_of_item, output ready);
endinterface

// ----- rtl/nal_unit_splitter.sv -----
// top level of the nal unit splitter: front, result queue and back
// depends on nus_pkg, nus_if, nus_front, nus_queue, nus_back
//
// bytes: one packet byte per item, last_byte marks the packet's final byte.
// units: one item per nal unit found, with offset, length, end_of_frame,
//   oversize and final_of_item (set on the last item caused by one byte).
// cfg_we / cfg_wdata: writes max_unit_len (reset value 1200); write only
//   while no byte is in flight.
// throughput: one byte per cycle. a byte makes zero, one or two items;
//   the four-entry queue takes two at once, the back drains one per
//   cycle unless the receiver stalls, so bytes are held off only when
//   the queue is nearly full. a result item is written into the queue
//   when its byte is accepted and then moves on to the output register.
// reset: all parse state and the queue are cleared, the output is empty
//   and max_unit_len goes back to 1200.
// receiver stall: the output register holds its item; the queue fills and
//   then bytes.ready drops until room for two items returns.

module nal_unit_splitter import nus_pkg::*; #(
	parameter int unsigned PACKET_BYTES_MAX = 65536
) (
	input  logic            clk,
	input  logic            arst_n,
	nus_byte_if.sink        bytes,
	nus_unit_if.source      units,
	input  logic            cfg_we,
	input  logic [LenW-1:0] cfg_wdata
);

	push_t     push;
	logic      space_ok;
	logic      pop;
	logic      not_empty;
	unit_res_t head;

	nus_front #(
		.PACKET_BYTES_MAX (PACKET_BYTES_MAX)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.bytes     (bytes),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.space_ok  (space_ok),
		.push      (push)
	);

	nus_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space_ok  (space_ok),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	nus_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.units     (units)
	);

endmodule

// ----- rtl/nus_front.sv -----
// front part: accepts bytes, tracks start codes and unit bounds, and
// pushes zero, one or two result items per byte; depends on nus_pkg, nus_if

module nus_front import nus_pkg::*; #(
	parameter int unsigned PACKET_BYTES_MAX = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	nus_byte_if.sink         bytes,
	input  logic             cfg_we,
	input  logic [LenW-1:0]  cfg_wdata,
	input  logic             space_ok,
	output push_t            push
);

	localparam int unsigned PosCapInt =
		((PACKET_BYTES_MAX - 1) > 65535) ? 65535 : (PACKET_BYTES_MAX - 1);
	localparam logic [PosW-1:0] PosCap = PosW'(PosCapInt);

	logic [LenW-1:0] max_len_q;
	logic [PosW-1:0] pos_q;
	logic [31:0]     recent_q;
	logic            in_unit_q;
	logic [PosW-1:0] start_q;
	logic            dropping_q;

	logic              accept;
	logic              code;
	logic              drop_zero;
	logic signed [17:0] d1;
	logic [LenW-1:0]   len1;
	logic              over1;
	logic              r1;
	logic              r2;
	logic              in_new;
	logic              dropping_new;
	logic [PosW-1:0]   start_new;
	logic [16:0]       sum2;
	logic [LenW-1:0]   len2;
	unit_res_t         res1;
	unit_res_t         res2;

	assign bytes.ready = space_ok;
	assign accept      = bytes.valid && space_ok;

	always_comb begin
		code      = (pos_q >= StartSkip) && (recent_q[23:0] == 24'h000001);
		// a zero before the start code belongs to a four-byte code
		drop_zero = (recent_q[31:24] == 8'd0) &&
			({1'b0, pos_q} >= ({1'b0, start_q} + 17'd4));
		d1 = $signed({2'b00, pos_q}) - $signed({2'b00, start_q}) - 18'sd3
			- $signed({17'd0, drop_zero});
		len1  = d1[17] ? '0 : d1[LenW-1:0];
		over1 = len1 > max_len_q;

		r1           = !dropping_q && code && in_unit_q;
		dropping_new = dropping_q || (r1 && over1);
		in_new       = in_unit_q;
		start_new    = start_q;
		if (r1 && over1) begin
			in_new = 1'b0;
		end
		if (!dropping_q && code && !dropping_new) begin
			in_new    = 1'b1;
			start_new = pos_q;
		end

		sum2 = {1'b0, pos_q} - {1'b0, start_new} + 17'd1;
		len2 = sum2[16] ? '1 : sum2[LenW-1:0];
		r2   = !dropping_q && bytes.last_byte && in_new && !dropping_new;

		res1.unit_offset   = start_q;
		res1.unit_length   = len1;
		res1.end_of_frame  = 1'b0;
		res1.oversize      = over1;
		res1.final_of_item = !r2;

		res2.unit_offset   = start_new;
		res2.unit_length   = len2;
		res2.end_of_frame  = 1'b1;
		res2.oversize      = len2 > max_len_q;
		res2.final_of_item = 1'b1;

		push.first  = r1 ? res1 : res2;
		push.second = res2;
		if (!accept) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, r1} + {1'b0, r2};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q  <= MaxLenRst;
			pos_q      <= '0;
			recent_q   <= '0;
			in_unit_q  <= 1'b0;
			start_q    <= '0;
			dropping_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				max_len_q <= cfg_wdata;
			end
			if (accept) begin
				if (bytes.last_byte) begin
					pos_q      <= '0;
					recent_q   <= '0;
					in_unit_q  <= 1'b0;
					start_q    <= '0;
					dropping_q <= 1'b0;
				end else begin
					recent_q   <= {recent_q[23:0], bytes.data_byte};
					if (pos_q < PosCap) begin
						pos_q <= pos_q + 16'd1;
					end
					in_unit_q  <= in_new;
					start_q    <= start_new;
					dropping_q <= dropping_new;
				end
			end
		end
	end

endmodule

// ----- rtl/nus_queue.sv -----
// result queue between front and back: two writes, one read per cycle
// depends on nus_pkg

module nus_queue import nus_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  push_t     push,
	output logic      space_ok,
	input  logic      pop,
	output logic      not_empty,
	output unit_res_t head
);

	unit_res_t            entry_q [QDepth];
	logic [QAddrW-1:0]    wr_ptr_q;
	logic [QAddrW-1:0]    rd_ptr_q;
	logic [QCountW-1:0]   count_q;
	logic [QAddrW-1:0]    wr_next;

	assign wr_next   = wr_ptr_q + QAddrW'(1);
	assign not_empty = count_q != '0;
	// room for the worst case of two items from one byte
	assign space_ok  = count_q <= QCountW'(QDepth - 2);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			entry_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			entry_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QAddrW'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAddrW'(1);
			end
			count_q <= count_q + QCountW'(push.count) - QCountW'(pop);
		end
	end

endmodule

// ----- rtl/nus_back.sv -----
// back part: takes result items from the queue into the output register
// and holds them until the receiver takes them; depends on nus_pkg, nus_if

module nus_back import nus_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      not_empty,
	input  unit_res_t head,
	output logic      pop,
	nus_unit_if.source units
);

	logic      valid_q;
	unit_res_t res_q;

	assign pop                 = not_empty && (!valid_q || units.ready);
	assign units.valid         = valid_q;
	assign units.unit_offset   = res_q.unit_offset;
	assign units.unit_length   = res_q.unit_length;
	assign units.end_of_frame  = res_q.end_of_frame;
	assign units.oversize      = res_q.oversize;
	assign units.final_of_item = res_q.final_of_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (units.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= head;
		end
	end

endmodule
